// ===== hdl/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared widths, calendar tables and constant-divide helpers for the
// Gregorian date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

	// field widths
	localparam int MW  = 4;   // month
	localparam int DW  = 5;   // day of month
	localparam int YW  = 14;  // input year
	localparam int OW  = 23;  // signed day offset
	localparam int SW  = 23;  // serial day of a corrected input date
	localparam int TW  = 26;  // signed serial + offset, covers MAX_YEAR up to 16383
	localparam int NW  = 25;  // zero-based result day
	localparam int RYW = 16;  // result year, up to 65535
	localparam int DNW = 22;  // day_number field
	localparam int Q4W = 8;   // count of 400-year cycles

	// queue between the front and back halves
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// cycle lengths in days
	localparam logic [17:0] DAYS_400Y = 18'd146097;
	localparam logic [15:0] DAYS_100Y = 16'd36524;
	localparam logic [10:0] DAYS_4Y   = 11'd1461;
	localparam logic [8:0]  DAYS_1Y   = 9'd365;

	// reciprocals, rounded up; shift chosen so that x*err < 2^K over the input range
	localparam int R400_K = 43;
	localparam longint unsigned R400_ML =
		((64'd1 << R400_K) + 64'd146097 - 64'd1) / 64'd146097;
	localparam logic [25:0] R400_M = 26'(R400_ML);

	localparam int R4_K = 27;
	localparam longint unsigned R4_ML = ((64'd1 << R4_K) + 64'd1461 - 64'd1) / 64'd1461;
	localparam logic [16:0] R4_M = 17'(R4_ML);

	localparam int DIV25_K = 19;
	localparam longint unsigned DIV25_ML = ((64'd1 << DIV25_K) + 64'd25 - 64'd1) / 64'd25;
	localparam logic [14:0] DIV25_M = 15'(DIV25_ML);

	localparam logic [MW-1:0] MONTH_JAN = 4'd1;
	localparam logic [MW-1:0] MONTH_FEB = 4'd2;
	localparam logic [MW-1:0] MONTH_DEC = 4'd12;

	// beat handed from the front half to the back half
	typedef struct packed {
		logic [NW-1:0] n;       // result date, days since 1/1/1
		logic [SW-1:0] serial;  // serial day of the corrected input
		logic          fixed;
		logic          sat;
	} gdad_item_t;

	// x / 25 for x < 2^14
	function automatic logic [9:0] div25(input logic [13:0] x);
		logic [28:0] pr;
		pr = 29'(x) * 29'(DIV25_M);
		return pr[28:DIV25_K];
	endfunction

	// days in a month of a common year
	function automatic logic [DW-1:0] month_len(input logic [MW-1:0] m);
		logic [DW-1:0] len;
		unique case (m) inside
			MONTH_FEB:                 len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// days before the first of a month in a common year
	function automatic logic [8:0] month_start(input logic [MW-1:0] m);
		logic [8:0] s;
		unique case (m)
			4'd1:    s = 9'd0;
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/gdad_front.sv =====
// ----------------------------------------------------------------------------
// gdad_front
// Corrects the input date, forms its serial day, adds the offset and
// saturates to the supported range. Five stages.
// ----------------------------------------------------------------------------
module gdad_front import gdad_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MW-1:0]        month_in,
	input  logic [DW-1:0]        day_in,
	input  logic [YW-1:0]        year_in,
	input  logic signed [OW-1:0] offset_days,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gdad_item_t           out_item
);

	localparam logic [16:0] MAXY = 17'(MAX_YEAR);
	localparam longint MS_L = longint'(MAX_YEAR) * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
		+ MAX_YEAR / 400;
	localparam logic signed [TW-1:0] MAX_SERIAL = TW'(MS_L);
	localparam logic [NW-1:0] MAX_N = NW'(MS_L - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	always_comb begin
		en5 = !v_s5 || out_ready;
		en4 = !v_s4 || en5;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
	end

	assign in_ready = en1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: month and year correction
	logic [MW-1:0] m_c, m_s1;
	logic [YW-1:0] y_c, y_s1;
	logic          fix_c, fix_s1;
	logic [DW-1:0] d_s1;
	logic signed [OW-1:0] off_s1;

	always_comb begin
		m_c = month_in;
		y_c = year_in;
		fix_c = 1'b0;
		if (month_in > MONTH_DEC) begin
			m_c = MONTH_DEC;
			fix_c = 1'b1;
		end else if (month_in == '0) begin
			m_c = MONTH_JAN;
			fix_c = 1'b1;
		end
		if (year_in == '0) begin
			y_c = 14'd1;
			fix_c = 1'b1;
		end else if ({3'b000, year_in} > MAXY) begin
			y_c = YW'(MAXY);
			fix_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			m_s1 <= m_c;
			y_s1 <= y_c;
			d_s1 <= day_in;
			off_s1 <= offset_days;
			fix_s1 <= fix_c;
		end
	end

	// stage 2: century quotients of the year and of the year before
	logic [MW-1:0] m_s2;
	logic [YW-1:0] y_s2, p_s2, p_c;
	logic [DW-1:0] d_s2;
	logic signed [OW-1:0] off_s2;
	logic fix_s2;
	logic [9:0] qy100_s2, qy400_s2, qp100_s2, qp400_s2;

	assign p_c = y_s1 - 14'd1;

	always_ff @(posedge clk) begin
		if (en2) begin
			m_s2 <= m_s1;
			y_s2 <= y_s1;
			p_s2 <= p_c;
			d_s2 <= d_s1;
			off_s2 <= off_s1;
			fix_s2 <= fix_s1;
			qy100_s2 <= div25({2'b00, y_s1[13:2]});
			qy400_s2 <= div25({4'b0000, y_s1[13:4]});
			qp100_s2 <= div25({2'b00, p_c[13:2]});
			qp400_s2 <= div25({4'b0000, p_c[13:4]});
		end
	end

	// stage 3: leap year, day clamp, days before the year
	logic leap_c, y4_c, y100_c, y400_c;
	logic [DW-1:0] len_c, d_c;
	logic [SW-1:0] dby_s3;
	logic [8:0] ms_s3;
	logic [DW-1:0] d_s3;
	logic signed [OW-1:0] off_s3;
	logic fix_s3;

	always_comb begin
		y4_c = (y_s2[1:0] == 2'b00);
		y100_c = y4_c && (y_s2[13:2] == 12'({2'b00, qy100_s2} * 12'd25));
		y400_c = (y_s2[3:0] == 4'b0000) && (y_s2[13:4] == 10'(qy400_s2 * 10'd25));
		leap_c = (y4_c && !y100_c) || y400_c;
		len_c = month_len(m_s2) + DW'(m_s2 == MONTH_FEB && leap_c);
		d_c = d_s2;
		if (d_s2 > len_c) d_c = len_c;
		else if (d_s2 == '0) d_c = 5'd1;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			dby_s3 <= SW'(p_s2) * 23'd365 + SW'(p_s2[13:2]) - SW'(qp100_s2) + SW'(qp400_s2);
			ms_s3 <= month_start(m_s2) + 9'(m_s2 > MONTH_FEB && leap_c);
			d_s3 <= d_c;
			off_s3 <= off_s2;
			fix_s3 <= fix_s2 || (d_s2 > len_c) || (d_s2 == '0);
		end
	end

	// stage 4: serial day
	logic [SW-1:0] serial_s4;
	logic signed [OW-1:0] off_s4;
	logic fix_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			serial_s4 <= dby_s3 + SW'(ms_s3) + SW'(d_s3);
			off_s4 <= off_s3;
			fix_s4 <= fix_s3;
		end
	end

	// stage 5: add the offset and saturate
	logic signed [TW-1:0] t_c;
	logic lo_c, hi_c;
	logic [NW-1:0] n_c;

	always_comb begin
		t_c = $signed({{(TW - SW){1'b0}}, serial_s4})
			+ $signed({{(TW - OW){off_s4[OW-1]}}, off_s4});
		lo_c = t_c[TW-1] || (t_c == '0);
		hi_c = t_c > MAX_SERIAL;
		if (lo_c) n_c = '0;
		else if (hi_c) n_c = MAX_N;
		else n_c = NW'(t_c - TW'(1));
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			out_item.n <= n_c;
			out_item.serial <= serial_s4;
			out_item.fixed <= fix_s4;
			out_item.sat <= lo_c || hi_c;
		end
	end

endmodule

// ===== hdl/gdad_queue.sv =====
// ----------------------------------------------------------------------------
// gdad_queue
// Small FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module gdad_queue import gdad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  gdad_item_t in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output gdad_item_t out_item
);

	gdad_item_t ent_q [QDEPTH];
	logic [QAW:0] wr_q, rd_q;
	logic full, empty, push, pop;

	assign empty = (wr_q == rd_q);
	assign full = (wr_q[QAW] != rd_q[QAW]) && (wr_q[QAW-1:0] == rd_q[QAW-1:0]);
	assign in_ready = !full;
	assign out_valid = !empty;
	assign push = in_valid && !full;
	assign pop = !empty && out_ready;
	assign out_item = ent_q[rd_q[QAW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q[QAW-1:0]] <= in_item;
	end

endmodule

// ===== hdl/gdad_back.sv =====
// ----------------------------------------------------------------------------
// gdad_back
// Splits a zero-based day count into year, month and day. Seven stages,
// the last one is the output register.
// ----------------------------------------------------------------------------
module gdad_back import gdad_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gdad_item_t     in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [MW-1:0]  month_out,
	output logic [DW-1:0]  day_out,
	output logic [YW-1:0]  year_out,
	output logic [DNW-1:0] day_number,
	output logic           input_corrected,
	output logic           range_saturated
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	always_comb begin
		en7 = !v_s7 || out_ready;
		en6 = !v_s6 || en7;
		en5 = !v_s5 || en6;
		en4 = !v_s4 || en5;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
	end

	assign in_ready = en1;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	gdad_item_t item_s1, item_s2, item_s3, item_s4, item_s5, item_s6;

	// stage 1: 400-year cycles by reciprocal multiply
	logic [50:0] pr400;
	logic [Q4W-1:0] q400_s1;

	assign pr400 = 51'(in_item.n) * 51'(R400_M);

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1 <= in_item;
			q400_s1 <= pr400[50:R400_K];
		end
	end

	// stage 2: remainder within the 400-year cycle
	logic [17:0] r400_s2;
	logic [RYW-1:0] yb_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			item_s2 <= item_s1;
			r400_s2 <= 18'(item_s1.n - NW'(NW'(q400_s1) * NW'(DAYS_400Y)));
			yb_s2 <= RYW'(q400_s1) * 16'd400;
		end
	end

	// stage 3: centuries, the fourth century absorbs the cycle's last day
	logic [1:0] q100_c, q100_s3;
	logic [15:0] r100_s3;
	logic [RYW-1:0] yb_s3;

	always_comb begin
		if (r400_s2 >= 18'd109572) q100_c = 2'd3;
		else if (r400_s2 >= 18'd73048) q100_c = 2'd2;
		else if (r400_s2 >= 18'(DAYS_100Y)) q100_c = 2'd1;
		else q100_c = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			item_s3 <= item_s2;
			q100_s3 <= q100_c;
			r100_s3 <= 16'(r400_s2 - 18'(q100_c) * 18'(DAYS_100Y));
			yb_s3 <= yb_s2 + RYW'(q100_c) * 16'd100;
		end
	end

	// stage 4: 4-year groups by reciprocal multiply
	logic [32:0] pr4;
	logic [4:0] q4_s4;
	logic [1:0] q100_s4;
	logic [15:0] r100_s4;
	logic [RYW-1:0] yb_s4;

	assign pr4 = 33'(r100_s3) * 33'(R4_M);

	always_ff @(posedge clk) begin
		if (en4) begin
			item_s4 <= item_s3;
			q4_s4 <= pr4[31:R4_K];
			q100_s4 <= q100_s3;
			r100_s4 <= r100_s3;
			yb_s4 <= yb_s3;
		end
	end

	// stage 5: remainder within the 4-year group
	logic [10:0] r4_s5;
	logic [4:0] q4_s5;
	logic [1:0] q100_s5;
	logic [RYW-1:0] yb_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			item_s5 <= item_s4;
			r4_s5 <= 11'(r100_s4 - 16'(q4_s4) * 16'(DAYS_4Y));
			q4_s5 <= q4_s4;
			q100_s5 <= q100_s4;
			yb_s5 <= yb_s4 + RYW'(q4_s4) * 16'd4;
		end
	end

	// stage 6: single years, leap flag from the decomposition itself
	logic [1:0] q1_c;
	logic [8:0] r1_s6;
	logic [RYW-1:0] ry_s6;
	logic leap_s6;

	always_comb begin
		if (r4_s5 >= 11'd1095) q1_c = 2'd3;
		else if (r4_s5 >= 11'd730) q1_c = 2'd2;
		else if (r4_s5 >= 11'(DAYS_1Y)) q1_c = 2'd1;
		else q1_c = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			item_s6 <= item_s5;
			r1_s6 <= 9'(r4_s5 - 11'(q1_c) * 11'(DAYS_1Y));
			ry_s6 <= yb_s5 + RYW'(q1_c) + 16'd1;
			// year divisible by 4 ends a group; by 100 unless it also ends a 400-year span
			leap_s6 <= (q1_c == 2'd3) && ((q4_s5 != 5'd24) || (q100_s5 == 2'd3));
		end
	end

	// stage 7: month search and day, output register
	logic [MW-1:0] rm_c;
	logic [8:0] st_c;

	always_comb begin
		rm_c = MONTH_JAN;
		for (int i = 2; i <= 12; i++) begin
			if (r1_s6 >= month_start(MW'(i)) + 9'(i > 2 && leap_s6)) rm_c = MW'(i);
		end
		st_c = month_start(rm_c) + 9'(rm_c > MONTH_FEB && leap_s6);
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			month_out <= rm_c;
			day_out <= DW'(r1_s6 - st_c + 9'd1);
			year_out <= YW'(ry_s6);
			day_number <= item_s6.serial[DNW-1:0];
			input_corrected <= item_s6.fixed;
			range_saturated <= item_s6.sat;
		end
	end

endmodule

// ===== hdl/gregorian_date_add_days.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a signed day offset to a corrected Gregorian date and returns the
// new date with the serial day of the input and two status flags.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat contents
//  -------  ---  ---------------------------------------------------------
//  s_axis   in   tdata: month_in, day_in, year_in, offset_days
//  m_axis   out  tdata: month_out, day_out, year_out, day_number
//                tuser: input_corrected, range_saturated
//
//  Throughput is one beat per clock while m_axis_tready stays high. A beat
//  passes 5 front stages, the queue and 7 back stages to the output register.
//  The front corrects the date, builds the serial day and saturates the sum;
//  the back splits the day count into 400/100/4/1-year groups and a month.
//  A 4-entry queue lets the back stall on m_axis_tready while the front keeps
//  accepting; s_axis_tready drops only once the queue and front are full.
//  Reset clears valid state only; no clearing pass is needed.
//
module gregorian_date_add_days import gdad_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // month_in, day_in, year_in, offset_days
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // month_out, day_out, year_out, day_number
	output logic [1:0]  m_axis_tuser    // input_corrected, range_saturated
);

	// input beat fields
	logic [MW-1:0] month_in;
	logic [DW-1:0] day_in;
	logic [YW-1:0] year_in;
	logic signed [OW-1:0] offset_days;

	assign month_in = s_axis_tdata[3:0];
	assign day_in = s_axis_tdata[8:4];
	assign year_in = s_axis_tdata[22:9];
	assign offset_days = $signed(s_axis_tdata[45:23]);

	// front to queue
	logic f_valid, f_ready;
	gdad_item_t f_item;

	// queue to back
	logic q_valid, q_ready;
	gdad_item_t q_item;

	// result fields
	logic [MW-1:0] month_out;
	logic [DW-1:0] day_out;
	logic [YW-1:0] year_out;
	logic [DNW-1:0] day_number;
	logic input_corrected, range_saturated;

	gdad_front #(
		.MAX_YEAR(MAX_YEAR)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.month_in    (month_in),
		.day_in      (day_in),
		.year_in     (year_in),
		.offset_days (offset_days),
		.out_valid   (f_valid),
		.out_ready   (f_ready),
		.out_item    (f_item)
	);

	gdad_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	gdad_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (q_valid),
		.in_ready        (q_ready),
		.in_item         (q_item),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.month_out       (month_out),
		.day_out         (day_out),
		.year_out        (year_out),
		.day_number      (day_number),
		.input_corrected (input_corrected),
		.range_saturated (range_saturated)
	);

	// pack result beat, low field first, zero fill to 48 bits
	assign m_axis_tdata = {3'b000, day_number, year_out, day_out, month_out};
	assign m_axis_tuser = {range_saturated, input_corrected};

	// a result date is always a real calendar month and day
	a_month_day: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (month_out >= MONTH_JAN) && (month_out <= MONTH_DEC)
			&& (day_out != '0))
		else $error("result month or day out of range");

	// February never runs past day 29
	a_feb_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && month_out == MONTH_FEB) |-> (day_out <= 5'd29))
		else $error("February day past 29");

	// a saturated result sits on one end of the range
	a_sat_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && range_saturated) |->
			((month_out == MONTH_JAN && day_out == 5'd1 && year_out == 14'd1)
			|| (month_out == MONTH_DEC && day_out == 5'd31
				&& year_out == YW'(MAX_YEAR))))
		else $error("saturated result not at a range end");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gregorian date adder. A directed table hits the
// range ends, every correction and the leap and century edges. Random dates
// follow: mostly valid, some near boundaries, plus raw bit noise. Each output
// beat is checked against a hand-typed result or an in-bench calendar model.
// Both sides idle at random; one long receiver stall backs the pipe up fully.
// ----------------------------------------------------------------------------
module tb_top;
	import gdad_pkg::*;

	localparam int YEAR_CAP     = 9999;
	localparam int RANDOM_DATES = 1050;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;      // margin beyond the pipe latency
	localparam int HOLD_AFTER   = 300;     // output beats before the long hold-off
	localparam int HOLD_CYCLES  = 400;

	// calendar cycle lengths in days
	localparam int CYC400 = 146097;
	localparam int CYC100 = 36524;
	localparam int CYC4   = 1461;
	localparam int CYC1   = 365;

	// input beat, month in the low bits
	typedef struct packed {
		logic [OW-1:0] offset;
		logic [YW-1:0] year;
		logic [DW-1:0] day;
		logic [MW-1:0] month;
	} date_in_t;

	// tdata of an output beat, month in the low bits
	typedef struct packed {
		logic [DNW-1:0] day_number;
		logic [YW-1:0]  year;
		logic [DW-1:0]  day;
		logic [MW-1:0]  month;
	} date_out_t;

	typedef struct packed {
		logic [MW-1:0]  month;
		logic [DW-1:0]  day;
		logic [YW-1:0]  year;
		logic [DNW-1:0] day_number;
		logic           corrected;
		logic           saturated;
	} cal_result_t;

	typedef struct {
		date_in_t    din;
		bit          typed;   // want holds a hand-typed result
		cal_result_t want;
	} date_job_t;

	// directed row: inputs, then the result where it is obvious by eye
	typedef struct {
		int m, d, y, off;
		bit typed;
		int em, ed, ey, edn;
		bit ec, es;
	} dir_row_t;

	typedef enum int { RX_OPEN, RX_COIN, RX_PATTERN, RX_MOSTLY } rx_mode_t;

	localparam int NDIR = 25;
	dir_row_t date_table [NDIR] = '{
		// range ends and saturation
		'{1, 1, 1, 0,                 1, 1, 1, 1, 1,              0, 0},
		'{1, 1, 1, -1,                1, 1, 1, 1, 1,              0, 1},
		'{12, 31, 9999, 1,            1, 12, 31, 9999, 3652059,   0, 1},
		'{12, 31, 9999, 0,            1, 12, 31, 9999, 3652059,   0, 0},
		'{0, 0, 0, 0,                 1, 1, 1, 1, 1,              1, 0},
		'{15, 31, 16383, 4194303,     1, 12, 31, 9999, 3652059,   1, 1},
		'{1, 1, 1, -4194304,          1, 1, 1, 1, 1,              0, 1},
		'{12, 31, 9999, -4194304,     1, 1, 1, 1, 3652059,        0, 1},
		'{1, 1, 1, 4194303,           1, 12, 31, 9999, 1,         0, 1},
		// leap days, clamps and year-boundary crossings
		'{2, 29, 2000, 0,             0, 0, 0, 0, 0, 0, 0},
		'{2, 29, 1900, 0,             0, 0, 0, 0, 0, 0, 0},
		'{2, 31, 2004, 0,             0, 0, 0, 0, 0, 0, 0},
		'{4, 31, 2023, 0,             0, 0, 0, 0, 0, 0, 0},
		'{13, 15, 2023, 0,            0, 0, 0, 0, 0, 0, 0},
		'{6, 0, 2023, 0,              0, 0, 0, 0, 0, 0, 0},
		'{12, 31, 1999, 1,            0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 2001, -1,             0, 0, 0, 0, 0, 0, 0},
		'{12, 31, 2000, 1,            0, 0, 0, 0, 0, 0, 0},
		'{2, 28, 2100, 1,             0, 0, 0, 0, 0, 0, 0},
		'{12, 31, 400, 0,             0, 0, 0, 0, 0, 0, 0},
		'{12, 31, 4, 0,               0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 2024, 59,             0, 0, 0, 0, 0, 0, 0},
		'{3, 15, 2024, -10000,        0, 0, 0, 0, 0, 0, 0},
		'{7, 4, 1776, 2000000,        0, 0, 0, 0, 0, 0, 0},
		'{10, 20, 5000, -1500000,     0, 0, 0, 0, 0, 0, 0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;    // month_in, day_in, year_in, offset_days
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;         // month_out, day_out, year_out, day_number
	logic [1:0]  m_axis_tuser;         // input_corrected, range_saturated

	date_job_t   date_jobs[$];        // not yet driven
	cal_result_t pending_dates[$];    // accepted, result not yet seen
	date_job_t   on_bus;              // job currently offered on s_axis

	int issued, taken, returned, mismatches;
	int seen_corrected, seen_saturated;
	int cycles;

	gregorian_date_add_days #(.MAX_YEAR(YEAR_CAP)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// calendar model
	// ------------------------------------------------------------------------
	function automatic bit leap_year_f(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// days before 1/1 of year y
	function automatic int unsigned year_start_day(int unsigned y);
		int unsigned p;
		p = y - 1;
		return p * CYC1 + p / 4 - p / 100 + p / 400;
	endfunction

	function automatic int unsigned month_offset(int unsigned m, bit leap);
		int unsigned s;
		case (m)
			2:       s = 31;
			3:       s = 59;
			4:       s = 90;
			5:       s = 120;
			6:       s = 151;
			7:       s = 181;
			8:       s = 212;
			9:       s = 243;
			10:      s = 273;
			11:      s = 304;
			12:      s = 334;
			default: s = 0;
		endcase
		return s + ((m > 2 && leap) ? 1 : 0);
	endfunction

	function automatic int unsigned days_in_month(int unsigned m, bit leap);
		int unsigned len;
		case (m)
			2:             len = leap ? 29 : 28;
			4, 6, 9, 11:   len = 30;
			default:       len = 31;
		endcase
		return len;
	endfunction

	// corrected date + offset -> new date, serial day of the input, flags
	function automatic cal_result_t shift_date(date_in_t a);
		int unsigned m, d, y, len, serial, top, n, r, q400, q100, q4, q1, ry, rm;
		longint sum;
		bit fix, sat;
		cal_result_t o;
		m = a.month;
		d = a.day;
		y = a.year;
		fix = 1'b0;
		sat = 1'b0;
		if (m > 12) begin
			m = 12;
			fix = 1'b1;
		end else if (m == 0) begin
			m = 1;
			fix = 1'b1;
		end
		if (y == 0) begin
			y = 1;
			fix = 1'b1;
		end else if (y > YEAR_CAP) begin
			y = YEAR_CAP;
			fix = 1'b1;
		end
		len = days_in_month(m, leap_year_f(y));
		if (d > len) begin
			d = len;
			fix = 1'b1;
		end else if (d == 0) begin
			d = 1;
			fix = 1'b1;
		end
		serial = year_start_day(y) + month_offset(m, leap_year_f(y)) + d;
		top = year_start_day(YEAR_CAP + 1);

		sum = longint'(serial) + longint'($signed(a.offset));
		if (sum < 1) begin
			sum = 1;
			sat = 1'b1;
		end else if (sum > longint'(top)) begin
			sum = top;
			sat = 1'b1;
		end

		// split zero-based day into 400/100/4/1-year groups;
		// the last day of a long group stays in its fourth subgroup
		n = int'(sum) - 1;
		q400 = n / CYC400;
		r = n % CYC400;
		q100 = r / CYC100;
		if (q100 > 3)
			q100 = 3;
		r = r - q100 * CYC100;
		q4 = r / CYC4;
		r = r % CYC4;
		q1 = r / CYC1;
		if (q1 > 3)
			q1 = 3;
		r = r - q1 * CYC1;
		ry = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;

		rm = 1;
		for (int i = 2; i <= 12; i++) begin
			if (r >= month_offset(i, leap_year_f(ry)))
				rm = i;
		end

		o.month      = MW'(rm);
		o.day        = DW'(r - month_offset(rm, leap_year_f(ry)) + 1);
		o.year       = YW'(ry);
		o.day_number = DNW'(serial);
		o.corrected  = fix;
		o.saturated  = sat;
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// random dates: valid ones, month-edge crossings, range ends, raw noise
	// ------------------------------------------------------------------------
	function automatic date_in_t random_date();
		int unsigned pick, sel, m, d, y, len;
		int off, sgn;
		date_in_t a;
		pick = $urandom_range(0, 99);
		sel  = $urandom_range(0, 2);
		sgn  = $urandom_range(0, 1) ? 1 : -1;
		m    = $urandom_range(1, 12);
		y    = $urandom_range(1, YEAR_CAP);
		len  = days_in_month(m, leap_year_f(y));
		d    = $urandom_range(1, len);
		off  = int'($urandom_range(0, 800)) - 400;
		if (pick < 55) begin
			if (sel == 1)
				off = int'($urandom_range(0, 400000)) - 200000;
			else if (sel == 2)
				off = $signed(OW'($urandom));
		end else if (pick < 70) begin
			// first or last day of a month, stepping a little, about a year, or one to three 4-year groups
			d = $urandom_range(0, 1) ? len : 1;
			if (sel == 0)
				off = int'($urandom_range(0, 6)) - 3;
			else if (sel == 1)
				off = sgn * int'(CYC1 + $urandom_range(0, 1));
			else
				off = sgn * CYC4 * int'($urandom_range(1, 3));
		end else if (pick < 80) begin
			// close to either end of the supported range
			if ($urandom_range(0, 1)) begin
				y = $urandom_range(1, 3);
				off = -int'($urandom_range(0, 2000));
			end else begin
				y = $urandom_range(YEAR_CAP - 2, YEAR_CAP);
				off = $urandom_range(0, 2000);
			end
			len = days_in_month(m, leap_year_f(y));
			d = $urandom_range(1, len);
		end else begin
			m   = $urandom_range(0, 15);
			d   = $urandom_range(0, 31);
			y   = $urandom_range(0, 16383);
			off = $signed(OW'($urandom));
		end
		a.month  = MW'(m);
		a.day    = DW'(d);
		a.year   = YW'(y);
		a.offset = OW'(off);
		return a;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------------
	// s_axis driver: bursts of random length, random gaps between them
	// ------------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && taken != issued)) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (burst_left > 0 && date_jobs.size() > 0) begin
				on_bus = date_jobs.pop_front();
				s_axis_tdata  <= {2'b00, on_bus.din};
				s_axis_tvalid <= 1'b1;
				issued++;
				burst_left--;
			end else begin
				s_axis_tvalid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end
		end
	end

	// ------------------------------------------------------------------------
	// m_axis receiver: stall modes in segments, plus one long hold-off
	// ------------------------------------------------------------------------
	rx_mode_t    rx_mode   = RX_OPEN;
	int          seg_left  = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	logic [31:0] rx_pattern;
	int          pat_idx   = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && returned >= HOLD_AFTER) begin
				// input side keeps offering while the pipe and queue fill
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					rx_mode    = rx_mode_t'($urandom_range(0, 3));
					seg_left   = $urandom_range(16, 160);
					rx_pattern = $urandom;
				end
				seg_left--;
				case (rx_mode)
					RX_OPEN:    m_axis_tready <= 1'b1;
					RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
					RX_PATTERN: begin
						m_axis_tready <= rx_pattern[pat_idx % 32];
						pat_idx++;
					end
					default:    m_axis_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: record accepted dates, check returned beats in order
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		date_out_t   got;
		cal_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pending_dates.push_back(on_bus.typed ? on_bus.want : shift_date(on_bus.din));
				taken++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = date_out_t'(m_axis_tdata[44:0]);
				returned++;
				seen_corrected += m_axis_tuser[0];
				seen_saturated += m_axis_tuser[1];
				if (pending_dates.size() == 0) begin
					$error("output beat with no date pending: tdata %h tuser %b",
						m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					want = pending_dates.pop_front();
					check_field("month_out", want.month, got.month);
					check_field("day_out", want.day, got.day);
					check_field("year_out", want.year, got.year);
					check_field("day_number", want.day_number, got.day_number);
					check_field("input_corrected", want.corrected, m_axis_tuser[0]);
					check_field("range_saturated", want.saturated, m_axis_tuser[1]);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// sequence: build the jobs, reset, wait for the pipe to drain, report
	// ------------------------------------------------------------------------
	initial begin
		date_job_t job;
		for (int i = 0; i < NDIR; i++) begin
			job.din.month  = MW'(date_table[i].m);
			job.din.day    = DW'(date_table[i].d);
			job.din.year   = YW'(date_table[i].y);
			job.din.offset = OW'(date_table[i].off);
			job.typed      = date_table[i].typed;
			job.want.month      = MW'(date_table[i].em);
			job.want.day        = DW'(date_table[i].ed);
			job.want.year       = YW'(date_table[i].ey);
			job.want.day_number = DNW'(date_table[i].edn);
			job.want.corrected  = date_table[i].ec;
			job.want.saturated  = date_table[i].es;
			date_jobs.push_back(job);
		end
		job.typed = 1'b0;
		job.want  = '0;
		for (int i = 0; i < RANDOM_DATES; i++) begin
			job.din = random_date();
			date_jobs.push_back(job);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (date_jobs.size() > 0 || taken != issued)
			@(posedge clk);
		while (pending_dates.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d dates (%0d table rows, %0d random), got %0d back.",
			taken, NDIR, RANDOM_DATES, returned);
		$display("Beats with corrected input: %0d, with saturated result: %0d.",
			seen_corrected, seen_saturated);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
